FILE: rtl/core/assert_macros.svh
// assertion helpers for the cache tag store
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define SACT_CHECK(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// condition on the cycle after a trigger
`define SACT_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/sact_pkg.sv
`timescale 1ns / 1ps
// shared types and codes for the set-associative cache tag store
// no dependencies
package sact_pkg;

  localparam int WAY_IDX_W = 4;   // enough for up to 16 ways
  localparam int STAMP_W   = 32;

  typedef enum logic [2:0] {
    OP_READ   = 3'd0,
    OP_WRITE  = 3'd1,
    OP_FILL   = 3'd2,
    OP_LOCK   = 3'd3,
    OP_UNLOCK = 3'd4
  } op_e_t;

  localparam logic WP_WRITE_BACK = 1'b0;

  // way selection result for one set
  typedef struct packed {
    logic                 hit;
    logic [WAY_IDX_W-1:0] hit_way;
    logic                 has_invalid;
    logic [WAY_IDX_W-1:0] victim_way;
  } sel_t;

endpackage

FILE: rtl/core/sact_way_sel.sv
`timescale 1ns / 1ps
// tag compare and fifo victim choice across the ways of one set
// depends on sact_pkg
module sact_way_sel import sact_pkg::*; #(
  parameter int WAYS  = 4,
  parameter int TAG_W = 20
) (
  input  logic [WAYS-1:0]                 valid,
  input  logic [WAYS-1:0]                 lock,
  input  logic [WAYS-1:0][TAG_W-1:0]      tags,
  input  logic [WAYS-1:0][STAMP_W-1:0]    stamps,
  input  logic [TAG_W-1:0]                tag,
  output sel_t                            sel
);

  logic                 found;
  logic [WAY_IDX_W-1:0] hit_way;
  logic                 inv_found;
  logic [WAY_IDX_W-1:0] inv_way;
  logic [STAMP_W:0]     best_key;
  logic [STAMP_W:0]     key;
  logic [WAY_IDX_W-1:0] min_way;

  // locked ways sort after unlocked ones, so one compare covers both passes
  always_comb begin
    found     = 1'b0;
    hit_way   = '0;
    inv_found = 1'b0;
    inv_way   = '0;
    best_key  = '0;
    key       = '0;
    min_way   = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!found && valid[w] && (tags[w] == tag)) begin
        found   = 1'b1;
        hit_way = WAY_IDX_W'(w);
      end
      if (!inv_found && !valid[w]) begin
        inv_found = 1'b1;
        inv_way   = WAY_IDX_W'(w);
      end
      key = {lock[w], stamps[w]};
      if ((w == 0) || (key < best_key)) begin
        best_key = key;
        min_way  = WAY_IDX_W'(w);
      end
    end
    sel.hit         = found;
    sel.hit_way     = hit_way;
    sel.has_invalid = inv_found;
    sel.victim_way  = inv_found ? inv_way : min_way;
  end

endmodule

FILE: rtl/core/set_assoc_cache_tag_store_unit.sv
`timescale 1ns / 1ps
// Tag store of one set-associative cache level, fifo replacement with locking.
// Channels: in_ carries one access, fill, lock or unlock item (kind in
// in_tuser); out_ returns one result item per input item, in order.
// cfg_wr_en/cfg_wr_data set the write policy: 0 write-back, 1 write-through;
// write it only while no item is in flight.
// Each result leaves from the output register, so out_tdata is registered.
// Throughput: one item per cycle while out_ is not stalled. Stage one reads
// the set row of the tag and stamp memories into registers; stage two
// compares, picks the victim, writes the row back and loads the output
// register. A write-back of the same set by the item ahead is forwarded, so
// back-to-back items to one set are fine.
// Valid, dirty and lock bits are flip-flops; the tag and stamp memories need
// no clearing since entries are only read once their line is valid.
// Reset (rst_n low, synchronous) invalidates all lines, clears locks, dirty
// bits, the fill counter and the policy; the block is ready the cycle after.
// When out_tready is low the output register holds its item, stage two holds
// behind it and in_tready drops once both are full.
// SETS and LINE_BYTES are powers of two.
`include "assert_macros.svh"
module set_assoc_cache_tag_store_unit import sact_pkg::*; #(
  parameter int SETS       = 64,
  parameter int WAYS       = 4,
  parameter int LINE_BYTES = 64,
  parameter int ADDR_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,   // write_policy
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,      // address[31:0], line[39:32]
  input  logic [2:0]  in_tuser,      // operation[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata      // hit[0], line_idx[8:1], writeback_valid[9],
                                     // writeback_address[41:10], zero[47:42]
);

  localparam int LINES   = SETS * WAYS;
  localparam int LINE_W  = $clog2(LINES);
  localparam int SET_W   = $clog2(SETS);
  localparam int OFF_W   = $clog2(LINE_BYTES + 1) - 1;
  localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TAG_LSB = OFF_W + SET_W;
  localparam int EFF_AW  = (ADDR_BITS < 32) ? ADDR_BITS : 32;
  localparam int TAG_W   = (EFF_AW > TAG_LSB) ? (EFF_AW - TAG_LSB) : 1;
  localparam logic [31:0] AMASK =
    (ADDR_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ADDR_BITS) - 64'd1);

  // input split
  logic [31:0]      in_addr;
  logic [31:0]      in_blk;
  logic [31:0]      in_tag32;
  logic [SET_W-1:0] in_set;
  logic [TAG_W-1:0] in_tag;
  logic             in_acc;

  assign in_addr  = in_tdata[31:0] & AMASK;
  assign in_blk   = in_addr >> OFF_W;
  assign in_tag32 = in_addr >> TAG_LSB;
  assign in_set   = in_blk[SET_W-1:0];
  assign in_tag   = in_tag32[TAG_W-1:0];
  assign in_acc   = in_tvalid && in_tready;

  // state
  logic [LINES-1:0]   valid_r;
  logic [LINES-1:0]   dirty_r;
  logic [LINES-1:0]   lock_r;
  logic [STAMP_W-1:0] cnt_r;
  logic               policy_r;

  logic [WAYS-1:0][TAG_W-1:0]   tag_mem   [SETS];
  logic [WAYS-1:0][STAMP_W-1:0] stamp_mem [SETS];

  // stage two registers
  logic                         s1_v_r;
  logic [2:0]                   s1_op_r;
  logic [SET_W-1:0]             s1_set_r;
  logic [TAG_W-1:0]             s1_tag_r;
  logic [7:0]                   s1_line_r;
  logic [WAYS-1:0][TAG_W-1:0]   rd_tag_r;
  logic [WAYS-1:0][STAMP_W-1:0] rd_stamp_r;
  logic                         fwd_hit_r;
  logic [WAYS-1:0][TAG_W-1:0]   fwd_tag_r;
  logic [WAYS-1:0][STAMP_W-1:0] fwd_stamp_r;

  // output register
  logic        out_v_r;
  logic        o_hit_r;
  logic [7:0]  o_idx_r;
  logic        o_wbv_r;
  logic [31:0] o_wba_r;

  logic s1_go;
  assign s1_go     = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || s1_go;

  // stage two logic
  logic [WAYS-1:0][TAG_W-1:0]   tag_row;
  logic [WAYS-1:0][STAMP_W-1:0] stamp_row;
  logic [WAYS-1:0][TAG_W-1:0]   wr_tag_row;
  logic [WAYS-1:0][STAMP_W-1:0] wr_stamp_row;
  logic [WAYS-1:0]              way_valid;
  logic [WAYS-1:0]              way_lock;
  logic [31:0]                  base32;
  logic [31:0]                  line32;
  sel_t                         sel;
  logic [WAY_W-1:0]             vway;
  logic [LINE_W-1:0]            hit_flat;
  logic [LINE_W-1:0]            victim_flat;
  logic [LINE_W-1:0]            lk_flat;
  logic                         lk_in_range;
  logic                         is_access;
  logic                         is_fill;
  logic                         is_write;
  logic                         is_lock;
  logic                         is_unlock;
  logic                         fill_miss;
  logic                         wb_v;
  logic [31:0]                  wb_a;
  logic [31:0]                  res_idx32;

  assign tag_row   = fwd_hit_r ? fwd_tag_r   : rd_tag_r;
  assign stamp_row = fwd_hit_r ? fwd_stamp_r : rd_stamp_r;
  assign base32    = 32'(s1_set_r) * 32'(WAYS);
  assign line32    = 32'(s1_line_r);

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      way_valid[w] = valid_r[LINE_W'(base32 + 32'(w))];
      way_lock[w]  = lock_r[LINE_W'(base32 + 32'(w))];
    end
  end

  sact_way_sel #(
    .WAYS  (WAYS),
    .TAG_W (TAG_W)
  ) u_way_sel (
    .valid  (way_valid),
    .lock   (way_lock),
    .tags   (tag_row),
    .stamps (stamp_row),
    .tag    (s1_tag_r),
    .sel    (sel)
  );

  always_comb begin
    is_access = 1'b0;
    is_fill   = 1'b0;
    is_write  = 1'b0;
    is_lock   = 1'b0;
    is_unlock = 1'b0;
    unique case (s1_op_r)
      OP_READ:   is_access = 1'b1;
      OP_WRITE:  begin
        is_access = 1'b1;
        is_write  = 1'b1;
      end
      OP_FILL:   begin
        is_access = 1'b1;
        is_fill   = 1'b1;
      end
      OP_LOCK:   is_lock   = 1'b1;
      OP_UNLOCK: is_unlock = 1'b1;
      default:   ;  // undefined operations do nothing
    endcase
  end

  assign vway        = sel.victim_way[WAY_W-1:0];
  assign hit_flat    = LINE_W'(base32 + 32'(sel.hit_way));
  assign victim_flat = LINE_W'(base32 + 32'(sel.victim_way));
  assign lk_flat     = line32[LINE_W-1:0];
  assign lk_in_range = line32 < 32'(LINES);
  assign fill_miss   = is_fill && !sel.hit;

  // dirty victim only possible when the set is full
  assign wb_v = fill_miss && !sel.has_invalid && (policy_r == WP_WRITE_BACK)
                && dirty_r[victim_flat];
  assign wb_a = ((32'(tag_row[vway]) << TAG_LSB) | (32'(s1_set_r) << OFF_W)) & AMASK;

  always_comb begin
    res_idx32 = '0;
    if (is_access && sel.hit) begin
      res_idx32 = 32'(hit_flat);
    end else if (fill_miss) begin
      res_idx32 = 32'(victim_flat);
    end
  end

  always_comb begin
    wr_tag_row         = tag_row;
    wr_stamp_row       = stamp_row;
    wr_tag_row[vway]   = s1_tag_r;
    wr_stamp_row[vway] = cnt_r;
  end

  logic mem_we;
  assign mem_we = s1_go && fill_miss;

  // row memories
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tag_mem[s1_set_r]   <= wr_tag_row;
      stamp_mem[s1_set_r] <= wr_stamp_row;
    end
    if (in_acc) begin
      rd_tag_r   <= tag_mem[in_set];
      rd_stamp_r <= stamp_mem[in_set];
    end
  end

  // stage two payload, forwarding rows and output register fields
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r     <= in_tuser;
      s1_set_r    <= in_set;
      s1_tag_r    <= in_tag;
      s1_line_r   <= in_tdata[39:32];
      fwd_tag_r   <= wr_tag_row;
      fwd_stamp_r <= wr_stamp_row;
    end
    if (s1_go) begin
      o_hit_r <= is_access && sel.hit;
      o_idx_r <= res_idx32[7:0];
      o_wbv_r <= wb_v;
      o_wba_r <= wb_v ? wb_a : 32'd0;
    end
  end

  // control and line flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
      fwd_hit_r <= 1'b0;
      valid_r   <= '0;
      dirty_r   <= '0;
      lock_r    <= '0;
      cnt_r     <= '0;
      policy_r  <= WP_WRITE_BACK;
    end else begin
      if (cfg_wr_en) begin
        policy_r <= cfg_wr_data;
      end
      if (in_acc) begin
        s1_v_r    <= 1'b1;
        fwd_hit_r <= mem_we && (s1_set_r == in_set);
      end else if (s1_go) begin
        s1_v_r <= 1'b0;
      end
      if (s1_go) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
      if (s1_go) begin
        if (is_write && sel.hit && (policy_r == WP_WRITE_BACK)) begin
          dirty_r[hit_flat] <= 1'b1;
        end
        if (fill_miss) begin
          valid_r[victim_flat] <= 1'b1;
          dirty_r[victim_flat] <= 1'b0;
          lock_r[victim_flat]  <= 1'b0;
          cnt_r                <= cnt_r + 32'd1;
        end
        if ((is_lock || is_unlock) && lk_in_range) begin
          lock_r[lk_flat] <= is_lock;
        end
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'd0, o_wba_r, o_wbv_r, o_idx_r, o_hit_r};

  `SACT_CHECK(a_wb_not_on_hit, !(out_v_r && o_wbv_r && o_hit_r), "write-back on a hit")
  `SACT_CHECK(a_stall_only_full, in_tready || (s1_v_r && out_v_r), "input stalled with room")
  `SACT_CHECK_NEXT(a_cnt_step, s1_go && fill_miss, cnt_r == $past(cnt_r) + 32'd1, "counter stuck")
  `SACT_CHECK_NEXT(a_victim_valid, s1_go && fill_miss, valid_r[$past(victim_flat)], "fill not valid")

endmodule

FILE: bench/set_assoc_cache_tag_store_unit_tb.sv
`timescale 1ns / 1ps
// self-checking bench for the set-associative cache tag store: directed and random
// items through the stream channels, each result checked against an in-bench tag model
// depends on sact_pkg and set_assoc_cache_tag_store_unit
module set_assoc_cache_tag_store_unit_tb import sact_pkg::*;;

  localparam int SETS        = 64;
  localparam int WAYS        = 4;
  localparam int LINE_BYTES  = 64;
  localparam int LINES       = SETS * WAYS;
  localparam int OFFSET_BITS = 6;
  localparam int SET_BITS    = 6;
  localparam int TAG_BITS    = 32 - OFFSET_BITS - SET_BITS;
  localparam int STALL_LIMIT = 2000;

  localparam logic       WP_WRITE_THRU = 1'b1;
  localparam logic [2:0] OP_RSVD_LO    = 3'd5;
  localparam logic [2:0] OP_RSVD_HI    = 3'd7;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] addr;
    logic [7:0]  line;
  } cache_req_t;

  // same order as out_tdata[41:0]
  typedef struct packed {
    logic [31:0] wb_addr;
    logic        wb_valid;
    logic [7:0]  line_idx;
    logic        hit;
  } tag_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;

  // tag model state
  logic [TAG_BITS-1:0] line_tag [LINES];
  bit                  line_valid [LINES];
  bit                  line_dirty [LINES];
  bit                  line_locked [LINES];
  logic [31:0]         line_stamp [LINES];
  logic [31:0]         fill_count = '0;
  logic                model_policy = WP_WRITE_BACK;

  cache_req_t  pending_reqs[$];
  tag_result_t results_due[$];
  cache_req_t  req_on_bus;
  int unsigned items_issued = 0;
  int unsigned items_accepted = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned quiet_cycles = 0;
  int unsigned error_count = 0;

  logic [SET_BITS-1:0] hot_sets [4] = '{6'd0, 6'd63, 6'd21, 6'd42};
  logic [TAG_BITS-1:0] hot_tags [6] = '{20'h00000, 20'hFFFFF, 20'h00001,
                                        20'h80000, 20'h5A5A5, 20'h12345};

  set_assoc_cache_tag_store_unit #(
    .SETS      (SETS),
    .WAYS      (WAYS),
    .LINE_BYTES(LINE_BYTES),
    .ADDR_BITS (32)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < LINES; i++) begin
      line_tag[i]    = '0;
      line_valid[i]  = 1'b0;
      line_dirty[i]  = 1'b0;
      line_locked[i] = 1'b0;
      line_stamp[i]  = '0;
    end
  end

  // lookup, fill with fifo victim choice, lock and unlock
  function automatic tag_result_t predict_tag_store(cache_req_t req);
    tag_result_t         res;
    logic [SET_BITS-1:0] set_no;
    logic [TAG_BITS-1:0] tag;
    int                  base;
    int                  victim;
    int                  k;
    bit                  found;
    bit                  have;
    bit                  any;
    logic [31:0]         best;
    res    = '0;
    set_no = req.addr[OFFSET_BITS +: SET_BITS];
    tag    = req.addr[31 -: TAG_BITS];
    base   = int'(set_no) * WAYS;
    if (req.op == OP_READ || req.op == OP_WRITE || req.op == OP_FILL) begin
      found = 1'b0;
      for (int w = 0; w < WAYS; w++) begin
        if (!found && line_valid[base + w] && line_tag[base + w] == tag) begin
          found = 1'b1;
          res.line_idx = 8'(base + w);
        end
      end
      if (found) begin
        res.hit = 1'b1;
        if (req.op == OP_WRITE && model_policy == WP_WRITE_BACK)
          line_dirty[res.line_idx] = 1'b1;
      end else if (req.op == OP_FILL) begin
        have   = 1'b0;
        victim = base;
        for (int w = 0; w < WAYS; w++) begin
          if (!have && !line_valid[base + w]) begin
            have   = 1'b1;
            victim = base + w;
          end
        end
        if (!have) begin
          any  = 1'b0;
          best = '0;
          for (int w = 0; w < WAYS; w++) begin
            k = base + w;
            if (!line_locked[k] && (!any || line_stamp[k] < best)) begin
              any    = 1'b1;
              best   = line_stamp[k];
              victim = k;
            end
          end
          // every way locked: oldest of the whole set
          if (!any) begin
            for (int w = 0; w < WAYS; w++) begin
              k = base + w;
              if (!any || line_stamp[k] < best) begin
                any    = 1'b1;
                best   = line_stamp[k];
                victim = k;
              end
            end
          end
          if (model_policy == WP_WRITE_BACK && line_dirty[victim]) begin
            res.wb_valid = 1'b1;
            res.wb_addr  = {line_tag[victim], set_no, {OFFSET_BITS{1'b0}}};
          end
        end
        line_tag[victim]    = tag;
        line_valid[victim]  = 1'b1;
        line_dirty[victim]  = 1'b0;
        line_locked[victim] = 1'b0;
        line_stamp[victim]  = fill_count;
        fill_count          = fill_count + 32'd1;
        res.line_idx        = 8'(victim);
      end
    end else if (req.op == OP_LOCK || req.op == OP_UNLOCK) begin
      if (int'(req.line) < LINES)
        line_locked[req.line] = (req.op == OP_LOCK);
    end
    return res;
  endfunction

  // driver: takes the next request from the queue when the bus slot is free
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        results_due.insert(results_due.size(), predict_tag_store(req_on_bus));
        items_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          req_on_bus = pending_reqs[0];
          pending_reqs.delete(0);
          in_tvalid <= 1'b1;
          in_tdata  <= {req_on_bus.line, req_on_bus.addr};
          in_tuser  <= req_on_bus.op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endfunction

  // monitor: random back-pressure, in-order comparison of result items
  always @(posedge clk) begin
    tag_result_t want;
    tag_result_t got;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[41:0];
        if (results_due.size() == 0) begin
          $error("result item with none outstanding: 0x%0h", out_tdata);
          error_count++;
        end else begin
          want = results_due[0];
          results_due.delete(0);
          check_field("hit", 32'(want.hit), 32'(got.hit));
          check_field("line_idx", 32'(want.line_idx), 32'(got.line_idx));
          check_field("writeback_valid", 32'(want.wb_valid), 32'(got.wb_valid));
          check_field("writeback_address", want.wb_addr, got.wb_addr);
          check_field("padding", 32'd0, 32'(out_tdata[47:42]));
        end
      end
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // watchdog on cycles with no item moving on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic queue_req(logic [2:0] op, logic [31:0] addr, logic [7:0] line);
    cache_req_t req;
    req.op   = op;
    req.addr = addr;
    req.line = line;
    pending_reqs.insert(pending_reqs.size(), req);
    items_issued++;
  endtask

  task automatic wait_drained();
    wait (items_accepted == items_issued && results_due.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_policy_reg(logic value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    model_policy = value;
  endtask

  // mostly a few hot sets and tags so that hits, evictions and locks interact
  function automatic logic [31:0] pick_address();
    if ($urandom_range(4) == 0)
      return $urandom();
    return {hot_tags[$urandom_range(5)], hot_sets[$urandom_range(3)],
            OFFSET_BITS'($urandom_range(LINE_BYTES - 1))};
  endfunction

  function automatic logic [7:0] pick_line();
    if ($urandom_range(4) == 0)
      return 8'($urandom_range(255));
    return {hot_sets[$urandom_range(3)], 2'($urandom_range(WAYS - 1))};
  endfunction

  task automatic run_random(int unsigned count, logic policy_val,
                            int unsigned send_idle, int unsigned stall);
    int unsigned r;
    logic [2:0]  op;
    write_policy_reg(policy_val);
    send_idle_pct = send_idle;
    stall_pct     = stall;
    for (int unsigned i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 26)      op = OP_READ;
      else if (r < 52) op = OP_WRITE;
      else if (r < 82) op = OP_FILL;
      else if (r < 90) op = OP_LOCK;
      else if (r < 98) op = OP_UNLOCK;
      else             op = 3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
      queue_req(op, pick_address(), pick_line());
    end
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: set 0 through invalid ways, fifo order, locking, all-locked eviction
    write_policy_reg(WP_WRITE_BACK);
    queue_req(OP_READ,   32'h0000_0000, 8'd0);
    queue_req(OP_FILL,   32'h0000_0000, 8'd0);
    queue_req(OP_WRITE,  32'h0000_0000, 8'd0);
    queue_req(OP_FILL,   32'h0000_0000, 8'd0);
    queue_req(OP_FILL,   32'hFFFF_F03F, 8'd0);
    queue_req(OP_FILL,   32'h0000_1000, 8'd0);
    queue_req(OP_FILL,   32'h0000_2000, 8'd0);
    queue_req(OP_LOCK,   32'h0000_0000, 8'd0);
    queue_req(OP_FILL,   32'h0000_3000, 8'd0);
    queue_req(OP_WRITE,  32'h0000_2000, 8'd0);
    queue_req(OP_LOCK,   32'h0000_0000, 8'd1);
    queue_req(OP_LOCK,   32'h0000_0000, 8'd2);
    queue_req(OP_LOCK,   32'h0000_0000, 8'd3);
    queue_req(OP_FILL,   32'h0000_4000, 8'd0);
    queue_req(OP_UNLOCK, 32'h0000_0000, 8'd2);
    // top set: dirty line pushed out by later fills
    queue_req(OP_FILL,   32'hFFFF_FFFF, 8'd0);
    queue_req(OP_WRITE,  32'hFFFF_FFFF, 8'd0);
    queue_req(OP_FILL,   32'h0000_0FC0, 8'd0);
    queue_req(OP_FILL,   32'h0000_1FC0, 8'd0);
    queue_req(OP_FILL,   32'h0000_2FC0, 8'd0);
    queue_req(OP_FILL,   32'h0000_3FC0, 8'd0);
    queue_req(OP_RSVD_LO, 32'hFFFF_FFFF, 8'hFF);
    queue_req(OP_RSVD_HI, 32'hFFFF_FFFF, 8'hFF);
    queue_req(OP_LOCK,   32'hFFFF_FFFF, 8'hFF);
    queue_req(OP_UNLOCK, 32'hFFFF_FFFF, 8'hFF);
    wait_drained();

    run_random(500, WP_WRITE_BACK, 0, 0);
    run_random(400, WP_WRITE_THRU, 80, 0);
    run_random(400, WP_WRITE_BACK, 0, 80);
    run_random(350, WP_WRITE_THRU, 34, 34);
    run_random(350, WP_WRITE_BACK, 34, 34);

    repeat (8) @(posedge clk);
    if (error_count == 0 && results_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/sact_pkg.sv
rtl/core/sact_way_sel.sv
rtl/core/set_assoc_cache_tag_store_unit.sv
bench/set_assoc_cache_tag_store_unit_tb.sv
